// File: sv/pcli_pkg.sv
// Package with the shared constants and control types of the palette lookup block.
`timescale 1ns / 1ps

package pcli_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int COLOR_W      = 24;
    localparam int IDX_W        = 8;
    localparam int ADDR_W       = $clog2(PALETTE_SIZE);
    localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);

    typedef struct packed {
        logic load;
        logic search;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_status;

endpackage

// File: sv/pcli_ctrl.sv
// Controller state machine that sequences one palette search per transfer.
`timescale 1ns / 1ps

module pcli_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pcli_pkg::t_status i_status,
    output pcli_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_done
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        o_cmd.load   = (r_state == ST_IDLE) && start;
        o_cmd.search = (r_state == ST_SEARCH);
        o_cmd.finish = (r_state == ST_SEARCH) && (i_status.hit || i_status.miss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_SEARCH;
                        r_busy  <= 1'b1;
                    end
                end
                ST_SEARCH: begin
                    if (i_status.hit || i_status.miss) begin
                        r_state <= ST_IDLE;
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

// File: sv/pcli_dpath.sv
// Datapath with the palette memory, entry count, search counter and result registers.
`timescale 1ns / 1ps

module pcli_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcli_pkg::t_cmd                    i_cmd,
    input  logic [pcli_pkg::COLOR_W-1:0]      i_pixel_color,
    output pcli_pkg::t_status                 o_status,
    output logic [pcli_pkg::IDX_W-1:0]        o_palette_index,
    output logic                              o_is_new,
    output logic                              o_palette_full
);

    logic [pcli_pkg::COLOR_W-1:0] r_mem [pcli_pkg::PALETTE_SIZE];

    logic [pcli_pkg::COLOR_W-1:0] r_color;
    logic [pcli_pkg::COLOR_W-1:0] r_rdata;
    logic [pcli_pkg::CNT_W-1:0]   r_count;
    logic [pcli_pkg::CNT_W-1:0]   r_rd_addr;
    logic [pcli_pkg::ADDR_W-1:0]  r_cmp_idx;
    logic                         r_cmp_valid;
    logic [pcli_pkg::IDX_W-1:0]   r_index;
    logic                         r_is_new;
    logic                         r_full;

    logic hit;
    logic miss;
    logic full;
    logic issue;

    assign full  = (r_count == pcli_pkg::CNT_W'(pcli_pkg::PALETTE_SIZE));
    assign issue = i_cmd.search && (r_rd_addr != r_count);
    assign hit   = r_cmp_valid && (r_rdata == r_color);
    assign miss  = !hit && (r_rd_addr == r_count);

    always_comb begin
        o_status.hit  = hit;
        o_status.miss = miss;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_rd_addr[pcli_pkg::ADDR_W-1:0]];
        if (i_cmd.finish && miss && !full) begin
            r_mem[r_count[pcli_pkg::ADDR_W-1:0]] <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_addr   <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_addr   <= '0;
                r_cmp_valid <= 1'b0;
            end else if (issue) begin
                r_rd_addr   <= r_rd_addr + 1'b1;
                r_cmp_valid <= 1'b1;
            end else begin
                r_cmp_valid <= 1'b0;
            end
            if (i_cmd.finish && miss && !full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_color <= i_pixel_color;
        end
        if (issue) begin
            r_cmp_idx <= r_rd_addr[pcli_pkg::ADDR_W-1:0];
        end
        if (i_cmd.finish) begin
            if (hit) begin
                r_index  <= pcli_pkg::IDX_W'(r_cmp_idx);
                r_is_new <= 1'b0;
                r_full   <= 1'b0;
            end else if (!full) begin
                r_index  <= pcli_pkg::IDX_W'(r_count);
                r_is_new <= 1'b1;
                r_full   <= 1'b0;
            end else begin
                r_index  <= '0;
                r_is_new <= 1'b0;
                r_full   <= 1'b1;
            end
        end
    end

    assign o_palette_index = r_index;
    assign o_is_new        = r_is_new;
    assign o_palette_full  = r_full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pcli_pkg::CNT_W'(pcli_pkg::PALETTE_SIZE))
        else $error("entry count exceeds palette size");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_addr <= r_count)
        else $error("search address ran past the entry count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !hit && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry count did not advance on insert");

    a_hit_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && hit) |=> $stable(r_count))
        else $error("entry count changed on a matched color");
`endif

endmodule

// File: sv/palette_color_lookup_insert.sv
// Top level of the palette lookup block that joins controller and datapath.
//
//   Channel   Direction  Handshake              Payload
//   command   in         start high, busy low   i_pixel_color
//   result    out        o_done one-cycle pulse o_palette_index, o_is_new, o_palette_full
//
// The result strobe rises when the search ends. N is the entry count, up to PALETTE_SIZE:
// the single memory read port compares one entry a cycle, a match at index i ends the search
// there, and a miss ends it after all N entries have been compared.
// A new command may be given in the cycle that the result strobe is high.
// Reset clears the entry count and the search state; the memory holds no valid data until written.
// The receiver cannot stall; each result is held until the next search ends, and o_done marks it.
`timescale 1ns / 1ps

module palette_color_lookup_insert (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [pcli_pkg::COLOR_W-1:0]  i_pixel_color,
    output logic                          busy,
    output logic                          o_done,
    output logic [pcli_pkg::IDX_W-1:0]    o_palette_index,
    output logic                          o_is_new,
    output logic                          o_palette_full
);

    pcli_pkg::t_cmd    cmd;
    pcli_pkg::t_status status;

    pcli_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    pcli_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_pixel_color   (i_pixel_color),
        .o_status        (status),
        .o_palette_index (o_palette_index),
        .o_is_new        (o_is_new),
        .o_palette_full  (o_palette_full)
    );

endmodule
